// File: rtl/brpc_pkg.sv
package brpc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 40;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 8;

  typedef logic [1:0] op_t;
  localparam op_t OP_BUTTON = 2'd0;
  localparam op_t OP_SWITCH = 2'd1;
  localparam op_t OP_LOCK   = 2'd2;

  typedef logic [2:0] ev_t;
  localparam ev_t EV_NONE    = 3'd0;
  localparam ev_t EV_PRESS   = 3'd1;
  localparam ev_t EV_RELEASE = 3'd2;
  localparam ev_t EV_SHORT   = 3'd3;
  localparam ev_t EV_LONG    = 3'd4;
  localparam ev_t EV_APPLIED = 3'd5;
  localparam ev_t EV_BLOCKED = 3'd6;

  typedef logic [1:0] react_t;
  localparam react_t REACT_NONE   = 2'd0;
  localparam react_t REACT_ON     = 2'd1;
  localparam react_t REACT_OFF    = 2'd2;
  localparam react_t REACT_TOGGLE = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LONG_MODE    = 3'd0;
  localparam cfg_idx_t REG_DEBOUNCE     = 3'd1;
  localparam cfg_idx_t REG_LONG_PRESS   = 3'd2;
  localparam cfg_idx_t REG_FIRST_REACT  = 3'd3;
  localparam cfg_idx_t REG_SECOND_REACT = 3'd4;
  localparam cfg_idx_t REG_RELAY_DISC   = 3'd5;
  localparam cfg_idx_t REG_LOCK         = 3'd6;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic        long_press_mode;
    logic [7:0]  debounce_ms;
    logic [15:0] long_press_ms;
    react_t      first_reaction;
    react_t      second_reaction;
    logic        relay_disconnected;
    logic        lock_with_false;
  } cfg_t;

  typedef struct packed {
    logic debounced_level;
    logic seen_level;
    logic relay;
    logic short_st;
    logic long_st;
    logic lock_value;
  } flags_t;

  typedef struct packed {
    op_t              operation;
    logic [NOW_W-1:0] now_ms;
    logic             button_level;
    logic             bus_value;
  } item_t;

endpackage

// File: rtl/button_press_relay_controller_top.sv
// Button relay controller: debounces timestamped button samples (toggle or short/long press
// mode), applies the configured reactions to the relay and status bits, and passes or blocks
// bus switch commands by the lock value. Every accepted word yields exactly one result word.
// One word is taken per cycle, back to back, while out_tready keeps up; the input register
// feeds the single update stage, whose outcome is caught by the result register when it is
// free or out_tready is high. While a result waits for out_tready the input is held off.
// Write configuration only while no word is in flight.
module button_press_relay_controller_top #(
  parameter int TIME_BITS = brpc_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_ms[31:0], button_level[32], bus_value[33], zero[39:34]
  input  logic [brpc_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation[1:0]
  input  logic [brpc_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // relay_on[0], short_status[1], long_status[2], event_res[5:3], zero[7:6]
  output logic [brpc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  brpc_pkg::cfg_idx_t               cfg_index,
  input  logic [brpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                           s1_v_r;
  brpc_pkg::item_t                s1_item_r;
  logic                           out_v_r;
  logic [brpc_pkg::OUT_DATA_W-1:0] out_data_r;
  brpc_pkg::cfg_t                 cfg_r;
  brpc_pkg::flags_t               flags_r;
  brpc_pkg::flags_t               flags_nxt;
  logic [TIME_BITS-1:0]           stable_r;
  logic [TIME_BITS-1:0]           stable_nxt;
  logic [TIME_BITS-1:0]           press_r;
  logic [TIME_BITS-1:0]           press_nxt;
  brpc_pkg::ev_t                  ev;
  logic                           adv;
  brpc_pkg::item_t                in_item;

  assign in_item.operation    = in_tuser;
  assign in_item.now_ms       = in_tdata[brpc_pkg::NOW_W-1:0];
  assign in_item.button_level = in_tdata[brpc_pkg::NOW_W];
  assign in_item.bus_value    = in_tdata[brpc_pkg::NOW_W+1];

  assign adv        = s1_v_r && (!out_v_r || out_tready);
  assign in_tready  = !s1_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  brpc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg          (cfg_r),
    .item         (s1_item_r),
    .flags        (flags_r),
    .stable_since (stable_r),
    .press_start  (press_r),
    .flags_nxt    (flags_nxt),
    .stable_nxt   (stable_nxt),
    .press_nxt    (press_nxt),
    .ev           (ev)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) s1_item_r <= in_item;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (adv) begin
      out_data_r <= {2'b00, ev, flags_nxt.long_st, flags_nxt.short_st, flags_nxt.relay};
    end
  end

  // controller state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r.debounced_level  <= brpc_pkg::LEVEL_RELEASED;
      flags_r.seen_level       <= brpc_pkg::LEVEL_RELEASED;
      flags_r.relay            <= 1'b0;
      flags_r.short_st         <= 1'b0;
      flags_r.long_st          <= 1'b0;
      flags_r.lock_value       <= 1'b0;
      stable_r                 <= '0;
      press_r                  <= '0;
      cfg_r.long_press_mode    <= 1'b0;
      cfg_r.debounce_ms        <= brpc_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms      <= brpc_pkg::LONG_PRESS_RST;
      cfg_r.first_reaction     <= brpc_pkg::REACT_NONE;
      cfg_r.second_reaction    <= brpc_pkg::REACT_NONE;
      cfg_r.relay_disconnected <= 1'b0;
      cfg_r.lock_with_false    <= 1'b0;
    end else begin
      if (adv) begin
        flags_r  <= flags_nxt;
        stable_r <= stable_nxt;
        press_r  <= press_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          brpc_pkg::REG_LONG_MODE:    cfg_r.long_press_mode    <= cfg_wdata[0];
          brpc_pkg::REG_DEBOUNCE:     cfg_r.debounce_ms        <= cfg_wdata[7:0];
          brpc_pkg::REG_LONG_PRESS:   cfg_r.long_press_ms      <= cfg_wdata[15:0];
          brpc_pkg::REG_FIRST_REACT:  cfg_r.first_reaction     <= cfg_wdata[1:0];
          brpc_pkg::REG_SECOND_REACT: cfg_r.second_reaction    <= cfg_wdata[1:0];
          brpc_pkg::REG_RELAY_DISC:   cfg_r.relay_disconnected <= cfg_wdata[0];
          brpc_pkg::REG_LOCK: begin
            cfg_r.lock_with_false <= cfg_wdata[0];
            flags_r.lock_value    <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_switch_applied: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item_r.operation == brpc_pkg::OP_SWITCH &&
    flags_r.lock_value == cfg_r.lock_with_false && !cfg_we
    |=> out_tdata[0] == $past(s1_item_r.bus_value) && flags_r.relay == out_tdata[0])
    else $error("bus switch not applied to relay");

  a_disconnected: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item_r.operation == brpc_pkg::OP_BUTTON && cfg_r.relay_disconnected
    |=> flags_r.relay == $past(flags_r.relay))
    else $error("button reaction drove disconnected relay");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("processed word produced no result");
`endif

endmodule

// File: rtl/brpc_step.sv
module brpc_step #(
  parameter int TIME_BITS = brpc_pkg::TIME_BITS_DEF
) (
  input  brpc_pkg::cfg_t         cfg,
  input  brpc_pkg::item_t        item,
  input  brpc_pkg::flags_t       flags,
  input  logic [TIME_BITS-1:0]   stable_since,
  input  logic [TIME_BITS-1:0]   press_start,
  output brpc_pkg::flags_t       flags_nxt,
  output logic [TIME_BITS-1:0]   stable_nxt,
  output logic [TIME_BITS-1:0]   press_nxt,
  output brpc_pkg::ev_t          ev
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] d_stable;
  logic [TIME_BITS-1:0] d_press;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] long_t;

  assign now_t    = TIME_BITS'(item.now_ms);
  assign d_stable = now_t - stable_since;
  assign d_press  = now_t - press_start;
  assign deb_t    = TIME_BITS'(cfg.debounce_ms);
  assign long_t   = TIME_BITS'(cfg.long_press_ms);

  always_comb begin
    brpc_pkg::react_t code;
    logic             react_en;
    logic             to_long;
    logic             v;
    logic             hit;
    flags_nxt  = flags;
    stable_nxt = stable_since;
    press_nxt  = press_start;
    ev         = brpc_pkg::EV_NONE;
    code       = brpc_pkg::REACT_NONE;
    react_en   = 1'b0;
    to_long    = 1'b0;
    case (item.operation)
      brpc_pkg::OP_BUTTON: begin
        if (!cfg.long_press_mode) begin
          if (item.button_level != flags.debounced_level) begin
            if (d_stable >= deb_t) begin
              flags_nxt.debounced_level = item.button_level;
              react_en = 1'b1;
              if (item.button_level == brpc_pkg::LEVEL_PRESSED) begin
                ev   = brpc_pkg::EV_PRESS;
                code = cfg.first_reaction;
              end else begin
                ev   = brpc_pkg::EV_RELEASE;
                code = cfg.second_reaction;
              end
            end
          end else begin
            stable_nxt = now_t;
          end
        end else if (item.button_level != flags.seen_level) begin
          flags_nxt.seen_level = item.button_level;
          if (item.button_level == brpc_pkg::LEVEL_PRESSED) begin
            press_nxt = now_t;
            ev        = brpc_pkg::EV_PRESS;
          end else if (d_press >= deb_t) begin
            react_en = 1'b1;
            if (d_press >= long_t) begin
              ev      = brpc_pkg::EV_LONG;
              code    = cfg.second_reaction;
              to_long = 1'b1;
            end else begin
              ev   = brpc_pkg::EV_SHORT;
              code = cfg.first_reaction;
            end
          end else begin
            ev = brpc_pkg::EV_RELEASE;
          end
        end
      end
      brpc_pkg::OP_SWITCH: begin
        if (flags.lock_value != cfg.lock_with_false) begin
          ev = brpc_pkg::EV_BLOCKED;
        end else begin
          flags_nxt.relay = item.bus_value;
          ev              = brpc_pkg::EV_APPLIED;
        end
      end
      brpc_pkg::OP_LOCK: begin
        flags_nxt.lock_value = item.bus_value;
      end
      default: begin
      end
    endcase

    hit = 1'b1;
    case (code)
      brpc_pkg::REACT_ON:     v = 1'b1;
      brpc_pkg::REACT_OFF:    v = 1'b0;
      brpc_pkg::REACT_TOGGLE: v = ~flags.short_st;
      default: begin
        v   = 1'b0;
        hit = 1'b0;
      end
    endcase
    if (react_en && hit) begin
      if (!cfg.relay_disconnected) flags_nxt.relay = v;
      if (to_long) flags_nxt.long_st = v;
      else flags_nxt.short_st = v;
    end
  end

endmodule
